@@ hw/rtl/i2c_mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c_mbe_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICK_W  = 10;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned BITS_W  = 4;

  localparam logic [TICK_W-1:0] TICKS_RESET = 10'd4;

  // command codes carried by an input item
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // sequence being run
  typedef enum logic [4:0] {
    KIND_IDLE  = 5'b00001,
    KIND_START = 5'b00010,
    KIND_STOP  = 5'b00100,
    KIND_WRITE = 5'b01000,
    KIND_READ  = 5'b10000
  } kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_level;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_received;
  } res_t;

endpackage

@@ hw/rtl/i2c_mbe_if.sv @@
// ----------------------------------------------------------------------------
// i2c_mbe_if
// Valid/ready channels of the I2C master byte engine: input, result, config.
// ----------------------------------------------------------------------------
interface i2c_mbe_in_if;
  logic                             valid;
  logic                             ready;
  logic [i2c_mbe_pkg::CMD_W-1:0]    command;
  logic [i2c_mbe_pkg::BYTE_W-1:0]   tx_byte;
  logic                             ack_level;
  logic                             sda_in;

  modport source (output valid, command, tx_byte, ack_level, sda_in, input ready);
  modport sink   (input valid, command, tx_byte, ack_level, sda_in, output ready);
endinterface

interface i2c_mbe_out_if;
  logic                             valid;
  logic                             ready;
  logic                             scl_out;
  logic                             sda_out;
  logic                             busy_res;
  logic                             done_res;
  logic [i2c_mbe_pkg::BYTE_W-1:0]   rx_byte;
  logic                             ack_received;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  ack_received, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  ack_received, output ready);
endinterface

interface i2c_mbe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [i2c_mbe_pkg::TICK_W-1:0]   ticks_per_phase;

  modport source (output valid, ticks_per_phase, input ready);
  modport sink   (input valid, ticks_per_phase, output ready);
endinterface

@@ hw/rtl/i2c_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Bit-level I2C master: start, stop, write byte and read byte sequences.
// ----------------------------------------------------------------------------
// Each input item is one tick of the bus sequencer and yields exactly one
// result item showing the SCL/SDA levels, busy/done flags, last received
// byte and last ACK after that tick. Throughput is one item per clock while
// the result side is ready. An accepted item waits in the input register,
// then is stepped into the sequencer state register, which also serves as
// the result register, once the result slot is free; the result is offered
// from that register until the result side takes it. Input ready stays high
// while the result is stalled, as long as the input register is empty.
// Commands are only honoured while idle; each SCL/SDA phase lasts
// ticks_per_phase ticks (0 behaves as 1).
// Write ticks_per_phase only while the engine is idle.
module i2c_master_byte_engine (
  input  logic               clk,
  input  logic               rst_n,
  i2c_mbe_in_if.sink         in_chan,
  i2c_mbe_out_if.source      out_chan,
  i2c_mbe_cfg_if.sink        cfg_chan
);

  logic [i2c_mbe_pkg::TICK_W-1:0] tpp_r;
  logic                           s0_valid_r;
  i2c_mbe_pkg::item_t             s0_item_r;
  logic                           out_valid_r;
  logic                           step_en;
  logic                           in_fire;
  i2c_mbe_pkg::res_t              res;

  // config register, always ready
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r <= i2c_mbe_pkg::TICKS_RESET;
    end else if (cfg_chan.valid) begin
      tpp_r <= cfg_chan.ticks_per_phase;
    end
  end

  // advance an item into the sequencer when the result slot is free
  assign step_en       = s0_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s0_valid_r || step_en;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s0_valid_r <= in_chan.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_item_r.command   <= in_chan.command;
      s0_item_r.tx_byte   <= in_chan.tx_byte;
      s0_item_r.ack_level <= in_chan.ack_level;
      s0_item_r.sda_in    <= in_chan.sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  i2c_mbe_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (step_en),
    .item            (s0_item_r),
    .ticks_per_phase (tpp_r),
    .res             (res)
  );

  assign out_chan.valid        = out_valid_r;
  assign out_chan.scl_out      = res.scl_out;
  assign out_chan.sda_out      = res.sda_out;
  assign out_chan.busy_res     = res.busy_res;
  assign out_chan.done_res     = res.done_res;
  assign out_chan.rx_byte      = res.rx_byte;
  assign out_chan.ack_received = res.ack_received;

endmodule

@@ hw/rtl/i2c_mbe_core.sv @@
// ----------------------------------------------------------------------------
// i2c_mbe_core
// Phase sequencer state; one tick per step, state doubles as result register.
// ----------------------------------------------------------------------------
module i2c_mbe_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  i2c_mbe_pkg::item_t              item,
  input  logic [i2c_mbe_pkg::TICK_W-1:0]  ticks_per_phase,
  output i2c_mbe_pkg::res_t               res
);

  i2c_mbe_pkg::kind_t                     kind_r, kind_nxt;
  logic [i2c_mbe_pkg::PHASE_W-1:0]        phase_r, phase_nxt, phase_inc;
  logic [i2c_mbe_pkg::BITS_W-1:0]         bits_r, bits_nxt;
  logic [i2c_mbe_pkg::TICK_W-1:0]         tick_r, tick_nxt, len;
  logic [i2c_mbe_pkg::TICK_W:0]           cnt;
  logic [i2c_mbe_pkg::BYTE_W-1:0]         shift_r, shift_nxt;
  logic [i2c_mbe_pkg::BYTE_W-1:0]         rx_r, rx_nxt;
  logic                                   nack_r, nack_nxt;
  logic                                   scl_r, scl_nxt;
  logic                                   sda_r, sda_nxt;
  logic                                   ack_r, ack_nxt;
  logic                                   done_r, done_nxt;
  logic                                   fin;
  logic                                   do_enter;

  assign len       = (ticks_per_phase == '0) ? 10'd1 : ticks_per_phase;
  assign cnt       = {1'b0, tick_r} + 11'd1;
  assign phase_inc = phase_r + 3'd1;

  always_comb begin
    kind_nxt  = kind_r;
    phase_nxt = phase_r;
    bits_nxt  = bits_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    rx_nxt    = rx_r;
    nack_nxt  = nack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    done_nxt  = 1'b0;
    fin       = 1'b0;
    do_enter  = 1'b0;

    if (kind_r == i2c_mbe_pkg::KIND_IDLE) begin
      case (item.command)
        i2c_mbe_pkg::CMD_START: kind_nxt = i2c_mbe_pkg::KIND_START;
        i2c_mbe_pkg::CMD_STOP:  kind_nxt = i2c_mbe_pkg::KIND_STOP;
        i2c_mbe_pkg::CMD_WRITE: kind_nxt = i2c_mbe_pkg::KIND_WRITE;
        i2c_mbe_pkg::CMD_READ:  kind_nxt = i2c_mbe_pkg::KIND_READ;
        default:                kind_nxt = i2c_mbe_pkg::KIND_IDLE;
      endcase
      if (kind_nxt != i2c_mbe_pkg::KIND_IDLE) begin
        phase_nxt = '0;
        bits_nxt  = '0;
        tick_nxt  = '0;
        shift_nxt = (kind_nxt == i2c_mbe_pkg::KIND_WRITE) ? item.tx_byte : '0;
        if (kind_nxt == i2c_mbe_pkg::KIND_READ) begin
          nack_nxt = item.ack_level;
        end
        do_enter = 1'b1;
      end
    end else if (cnt >= {1'b0, len}) begin
      // phase over
      tick_nxt  = '0;
      phase_nxt = phase_inc;
      case (kind_r)
        i2c_mbe_pkg::KIND_START: fin = (phase_r >= 3'd4);
        i2c_mbe_pkg::KIND_STOP:  fin = (phase_r >= 3'd3);
        i2c_mbe_pkg::KIND_WRITE: begin
          if (phase_r == 3'd2) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bits_nxt  = bits_r + 4'd1;
            phase_nxt = (bits_nxt >= 4'd8) ? 3'd3 : 3'd0;
          end else if (phase_r == 3'd4) begin
            ack_nxt = ~item.sda_in;
          end else if (phase_r >= 3'd5) begin
            fin = 1'b1;
          end
        end
        i2c_mbe_pkg::KIND_READ: begin
          if (phase_r == 3'd1) begin
            shift_nxt = {shift_r[6:0], item.sda_in};
            bits_nxt  = bits_r + 4'd1;
          end else if (phase_r == 3'd2) begin
            phase_nxt = (bits_r >= 4'd8) ? 3'd3 : 3'd1;
          end else if (phase_r >= 3'd5) begin
            rx_nxt = shift_r;
            fin    = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        kind_nxt  = i2c_mbe_pkg::KIND_IDLE;
        phase_nxt = '0;
        done_nxt  = 1'b1;
      end else begin
        do_enter = 1'b1;
      end
    end else begin
      tick_nxt = cnt[i2c_mbe_pkg::TICK_W-1:0];
    end

    // line levels of the phase being entered
    if (do_enter) begin
      case (kind_nxt)
        i2c_mbe_pkg::KIND_START: begin
          if (phase_nxt == 3'd0 || phase_nxt == 3'd4) scl_nxt = 1'b0;
          else if (phase_nxt == 3'd1)                 sda_nxt = 1'b1;
          else if (phase_nxt == 3'd2)                 scl_nxt = 1'b1;
          else                                        sda_nxt = 1'b0;
        end
        i2c_mbe_pkg::KIND_STOP: begin
          if (phase_nxt == 3'd0)      scl_nxt = 1'b0;
          else if (phase_nxt == 3'd1) sda_nxt = 1'b0;
          else if (phase_nxt == 3'd2) scl_nxt = 1'b1;
          else                        sda_nxt = 1'b1;
        end
        i2c_mbe_pkg::KIND_WRITE: begin
          if (phase_nxt == 3'd0)                           sda_nxt = shift_nxt[7];
          else if (phase_nxt == 3'd1 || phase_nxt == 3'd4) scl_nxt = 1'b1;
          else if (phase_nxt == 3'd2 || phase_nxt == 3'd5) scl_nxt = 1'b0;
          else                                             sda_nxt = 1'b1;
        end
        i2c_mbe_pkg::KIND_READ: begin
          if (phase_nxt == 3'd0) begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b1;
          end else if (phase_nxt == 3'd1 || phase_nxt == 3'd4) begin
            scl_nxt = 1'b1;
          end else if (phase_nxt == 3'd2 || phase_nxt == 3'd5) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt = nack_nxt;
          end
        end
        default: begin
          scl_nxt = scl_r;
          sda_nxt = sda_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= i2c_mbe_pkg::KIND_IDLE;
      phase_r <= '0;
      bits_r  <= '0;
      tick_r  <= '0;
      shift_r <= '0;
      rx_r    <= '0;
      nack_r  <= 1'b1;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      done_r  <= 1'b0;
    end else if (step_en) begin
      kind_r  <= kind_nxt;
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      rx_r    <= rx_nxt;
      nack_r  <= nack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      done_r  <= done_nxt;
    end
  end

  assign res.scl_out      = scl_r;
  assign res.sda_out      = sda_r;
  assign res.busy_res     = (kind_r != i2c_mbe_pkg::KIND_IDLE);
  assign res.done_res     = done_r;
  assign res.rx_byte      = rx_r;
  assign res.ack_received = ack_r;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (kind_r == i2c_mbe_pkg::KIND_IDLE))
    else $error("done raised while a sequence runs");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && step_en) |=> !done_r)
    else $error("done held for more than one tick");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == i2c_mbe_pkg::KIND_IDLE) |-> (phase_r == '0 && tick_r == '0))
    else $error("idle with phase or tick counter not cleared");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= 4'd8)
    else $error("bit counter past eight");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> ($stable(kind_r) && $stable(tick_r) && $stable(scl_r) && $stable(sda_r)))
    else $error("state moved without a tick");
`endif

endmodule
